/* design/spq_pkg.sv */
package spq_pkg;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] entry_id;
        logic [7:0] entry_priority;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] out_id;
        logic [7:0] out_priority;
        logic [4:0] occupancy;
    } out_item_t;

    // per-cell control: shift in on enqueue, shift out on dequeue
    typedef struct packed {
        logic enq;
        logic deq;
        logic valid;
        logic left_behind;
    } cell_ctrl_t;

endpackage

/* design/spq_cell.sv */
module spq_cell #(
    parameter int ID_BITS       = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                     clk,
    input  spq_pkg::cell_ctrl_t      ctrl,
    input  logic [ID_BITS-1:0]       new_id,
    input  logic [PRIORITY_BITS-1:0] new_priority,
    input  logic [ID_BITS-1:0]       left_id,
    input  logic [PRIORITY_BITS-1:0] left_priority,
    input  logic [ID_BITS-1:0]       right_id,
    input  logic [PRIORITY_BITS-1:0] right_priority,
    output logic [ID_BITS-1:0]       id,
    output logic [PRIORITY_BITS-1:0] priority_val,
    output logic                     behind
);
    import spq_pkg::*;

    logic [ID_BITS-1:0]       id_reg;
    logic [ID_BITS-1:0]       id_next;
    logic [PRIORITY_BITS-1:0] priority_reg;
    logic [PRIORITY_BITS-1:0] priority_next;

    // new item goes behind this entry
    assign behind       = ctrl.valid && (priority_reg >= new_priority);
    assign id           = id_reg;
    assign priority_val = priority_reg;

    always_comb
    begin
        id_next       = id_reg;
        priority_next = priority_reg;
        priority if (ctrl.enq && !behind)
        begin
            if (ctrl.left_behind)
            begin
                id_next       = new_id;
                priority_next = new_priority;
            end
            else
            begin
                id_next       = left_id;
                priority_next = left_priority;
            end
        end
        else if (ctrl.deq)
        begin
            id_next       = right_id;
            priority_next = right_priority;
        end
        else
        begin
            id_next       = id_reg;
            priority_next = priority_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        priority_reg <= priority_next;
    end

endmodule

/* design/stable_priority_queue.sv */
// Sorted queue of up to DEPTH entries (id, priority), highest priority at the
// head; equal priorities leave in arrival order. Each item is an enqueue or a
// dequeue of the head and yields one result with status, removed entry and
// count. One item per cycle unless an unread result stalls it: every cell
// compares its own priority with the new one in parallel and shifts by one
// place, so all cells update together; results sit in an output register.
module stable_priority_queue #(
    parameter int DEPTH         = 16,
    parameter int ID_BITS       = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  spq_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output spq_pkg::out_item_t  out_item
);
    import spq_pkg::*;

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [CNT_BITS-1:0]      count_reg;
    logic [CNT_BITS-1:0]      count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    out_item_t                out_reg;
    out_item_t                out_next;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     do_enq;
    logic                     do_deq;
    logic [ID_BITS-1:0]       new_id;
    logic [PRIORITY_BITS-1:0] new_priority;

    logic [ID_BITS-1:0]       cell_id       [DEPTH];
    logic [PRIORITY_BITS-1:0] cell_priority [DEPTH];
    logic [DEPTH-1:0]         cell_behind;

    assign in_ready     = !out_valid_reg || out_ready;
    assign accept       = in_valid && in_ready;
    assign full         = (count_reg == CNT_BITS'(DEPTH));
    assign empty        = (count_reg == '0);
    assign do_enq       = accept && (in_item.kind == KIND_ENQ) && !full;
    assign do_deq       = accept && (in_item.kind == KIND_DEQ) && !empty;
    assign new_id       = ID_BITS'(in_item.entry_id);
    assign new_priority = PRIORITY_BITS'(in_item.entry_priority);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            cell_ctrl_t               ctrl;
            logic [ID_BITS-1:0]       l_id;
            logic [PRIORITY_BITS-1:0] l_priority;
            logic [ID_BITS-1:0]       r_id;
            logic [PRIORITY_BITS-1:0] r_priority;

            assign ctrl.enq   = do_enq;
            assign ctrl.deq   = do_deq;
            assign ctrl.valid = (CNT_BITS'(g) < count_reg);

            if (g == 0)
            begin : g_first
                assign ctrl.left_behind = 1'b1;
                assign l_id             = new_id;
                assign l_priority       = new_priority;
            end
            else
            begin : g_mid
                assign ctrl.left_behind = cell_behind[g-1];
                assign l_id             = cell_id[g-1];
                assign l_priority       = cell_priority[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign r_id       = cell_id[g];
                assign r_priority = cell_priority[g];
            end
            else
            begin : g_inner
                assign r_id       = cell_id[g+1];
                assign r_priority = cell_priority[g+1];
            end

            spq_cell #(
                .ID_BITS       (ID_BITS),
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_cell (
                .clk            (clk),
                .ctrl           (ctrl),
                .new_id         (new_id),
                .new_priority   (new_priority),
                .left_id        (l_id),
                .left_priority  (l_priority),
                .right_id       (r_id),
                .right_priority (r_priority),
                .id             (cell_id[g]),
                .priority_val   (cell_priority[g]),
                .behind         (cell_behind[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            out_valid_next        = 1'b1;
            out_next.status       = ST_DONE;
            out_next.out_id       = '0;
            out_next.out_priority = '0;
            if (in_item.kind == KIND_ENQ)
            begin
                if (full)
                    out_next.status = ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            else
            begin
                if (empty)
                    out_next.status = ST_EMPTY;
                else
                begin
                    count_next            = count_reg - 1'b1;
                    out_next.out_id       = 8'(cell_id[0]);
                    out_next.out_priority = 8'(cell_priority[0]);
                end
            end
            out_next.occupancy = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule
